// ===== src/plg_pkg.sv =====
// Shared constants and types for the polygon shoelace area block.
// No dependencies; imported by every module under src except plg_fifo.
package plg_pkg;

  // Default parameter values handed down from the top level.
  localparam int unsigned CoordWidthDef  = 16;
  localparam int unsigned MaxVerticesDef = 1024;

  // Running cross-product sum wraps modulo 2^SumW.
  localparam int unsigned SumW   = 48;
  // Result area width, in half units (one implied fraction bit).
  localparam int unsigned AreaW  = 33;
  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  // Polygons with fewer vertices than this are flagged.
  localparam int unsigned TooFewLimit = 3;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // Per-vertex control flags travelling from front to back.
  typedef struct packed {
    logic first;    // opens a new polygon
    logic last;     // closes the polygon, a result follows
    logic too_few;  // polygon has fewer than three vertices so far
  } plg_ctrl_t;

  localparam int unsigned CtrlW = $bits(plg_ctrl_t);

endpackage

// ===== src/plg_fifo.sv =====
// Small register-based queue between the front and back parts.
// Depends on nothing but its parameters.
module plg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/plg_front.sv =====
// Front part: accepts vertices, tracks start and previous vertex and the count,
// and queues one operand record per vertex. Depends on plg_pkg.
module plg_front #(
  parameter int unsigned COORD_WIDTH  = plg_pkg::CoordWidthDef,
  parameter int unsigned MAX_VERTICES = plg_pkg::MaxVerticesDef,
  parameter int unsigned CNT_W        = $clog2(MAX_VERTICES + 1),
  parameter int unsigned ENTRY_W      = 6 * COORD_WIDTH + CNT_W + plg_pkg::CtrlW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] x_i,
  input  logic [COORD_WIDTH-1:0] y_i,
  input  logic                   last_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic [ENTRY_W-1:0]     entry_o
);
  import plg_pkg::*;

  logic [COORD_WIDTH-1:0] start_x_q, start_y_q;
  logic [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       count_inc;
  logic [COORD_WIDTH-1:0] sx, sy;
  plg_ctrl_t              ctrl;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign ctrl.first = (count_q == '0);
  assign ctrl.last  = last_i;
  assign count_inc  = (count_q < CNT_W'(MAX_VERTICES)) ? CNT_W'(count_q + 1'b1) : count_q;
  assign ctrl.too_few = (count_inc < CNT_W'(TooFewLimit));

  // A new polygon uses the incoming vertex as its own start point.
  assign sx = ctrl.first ? x_i : start_x_q;
  assign sy = ctrl.first ? y_i : start_y_q;

  assign entry_o = {ctrl, count_inc, sy, sx, y_i, x_i, prev_y_q, prev_x_q};

  assign count_d = last_i ? '0 : count_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      prev_x_q  <= x_i;
      prev_y_q  <= y_i;
      start_x_q <= sx;
      start_y_q <= sy;
    end
  end

endmodule

// ===== src/plg_back.sv =====
// Back part: multiplies, forms cross terms, accumulates and produces the
// saturated absolute sum in an output register. Depends on plg_pkg.
module plg_back #(
  parameter int unsigned COORD_WIDTH  = plg_pkg::CoordWidthDef,
  parameter int unsigned MAX_VERTICES = plg_pkg::MaxVerticesDef,
  parameter int unsigned CNT_W        = $clog2(MAX_VERTICES + 1),
  parameter int unsigned ENTRY_W      = 6 * COORD_WIDTH + CNT_W + plg_pkg::CtrlW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  logic [ENTRY_W-1:0]       entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [plg_pkg::AreaW-1:0] area_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     too_few_o
);
  import plg_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned ExtW = (PW > SumW) ? PW : SumW;

  // Unpacked queue record.
  logic signed [CW-1:0] ax, ay, bx, by, sx, sy;
  logic [CNT_W-1:0]     e_cnt;
  plg_ctrl_t            e_ctrl;

  assign {e_ctrl, e_cnt, sy, sx, by, bx, ay, ax} = entry_i;

  logic en;

  // Stage 1: products
  logic                 v1_q;
  plg_ctrl_t            c1_q;
  logic [CNT_W-1:0]     n1_q;
  logic signed [PW-1:0] p1_q, q1_q, p2_q, q2_q;

  // Stage 2: cross terms reduced to the sum width
  logic                 v2_q;
  plg_ctrl_t            c2_q;
  logic [CNT_W-1:0]     n2_q;
  logic [SumW-1:0]      t1_q, t1_d, t2_q, t2_d;
  logic signed [ExtW-1:0] p1_x, q1_x, p2_x, q2_x;

  // Stage 3: accumulator and finished sum
  logic                 v3_q;
  logic                 tf3_q;
  logic [CNT_W-1:0]     n3_q;
  logic [SumW-1:0]      sum_q, sum_d, fin_q;

  // Output register
  logic                 out_valid_q;
  logic [AreaW-1:0]     area_q, area_d;
  logic [CNT_W-1:0]     count_q;
  logic                 too_few_q;
  logic [SumW-1:0]      mag;

  // The whole pipe moves unless a result waits in the output register.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_empty_i;

  assign p1_x = ExtW'(p1_q);
  assign q1_x = ExtW'(q1_q);
  assign p2_x = ExtW'(p2_q);
  assign q2_x = ExtW'(q2_q);

  assign t1_d = c1_q.first ? '0 : SumW'(p1_x[SumW-1:0] - q1_x[SumW-1:0]);
  assign t2_d = c1_q.last  ? SumW'(p2_x[SumW-1:0] - q2_x[SumW-1:0]) : '0;

  assign sum_d = SumW'((c2_q.first ? '0 : sum_q) + t1_q + t2_q);

  assign mag    = fin_q[SumW-1] ? SumW'(SumW'(0) - fin_q) : fin_q;
  assign area_d = (|mag[SumW-1:AreaW]) ? AreaMax : mag[AreaW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= !q_empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q && c2_q.last;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= e_ctrl;
      n1_q <= e_cnt;
      p1_q <= ax * by;
      q1_q <= bx * ay;
      p2_q <= bx * sy;
      q2_q <= sx * by;

      c2_q <= c1_q;
      n2_q <= n1_q;
      t1_q <= t1_d;
      t2_q <= t2_d;

      if (v2_q) begin
        sum_q <= sum_d;
      end
      fin_q <= sum_d;
      n3_q  <= n2_q;
      tf3_q <= c2_q.too_few;

      area_q    <= area_d;
      count_q   <= n3_q;
      too_few_q <= tf3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_o      = area_q;
  assign count_o     = count_q;
  assign too_few_o   = too_few_q;

endmodule

// ===== src/polygon_shoelace_area.sv =====
// Top level of the streaming shoelace polygon area block.
// Depends on plg_pkg, plg_front, plg_fifo and plg_back.
//
// Vertices arrive as beats on the slave stream: x in the low COORD_WIDTH bits
// of tdata, y above it, and tlast set on the final vertex of a polygon. Every
// vertex after the first adds its cross product with the previous one to a
// running sum; the tlast beat also adds the closing edge to the first vertex.
// Each polygon yields one beat on the master stream: tdata carries the
// absolute sum (twice the area, saturated at 2^33-1) in the low 33 bits and
// the vertex count (saturating at MAX_VERTICES) above it; tuser is set when
// the polygon had fewer than three vertices. Vertices without tlast produce
// no output beat.
// Throughput is one vertex per clock cycle, sustained without gaps while the
// receiver takes results, set by the four multipliers of the back part which
// take a new operand set every cycle. After its last vertex is accepted, a
// result passes the queue, product, cross-term and accumulate stages, then
// the output register. If the receiver stalls, the result holds in the output
// register and the whole back pipeline freezes; the two-entry queue then fills
// and s_axis_tready_o drops. Reset clears the vertex count, the queue and all
// valid flags, so the first vertex after reset opens a new polygon.
module polygon_shoelace_area #(
  parameter int unsigned COORD_WIDTH  = plg_pkg::CoordWidthDef,
  parameter int unsigned MAX_VERTICES = plg_pkg::MaxVerticesDef,
  parameter int unsigned CNT_W        = $clog2(MAX_VERTICES + 1),
  parameter int unsigned IN_DATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_DATA_W   = ((plg_pkg::AreaW + CNT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // vertex_x, vertex_y, zero padding
  input  logic                  s_axis_tlast_i,   // last_vertex
  // Master stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // area_halves, vertex_count, zero padding
  output logic                  m_axis_tuser_o    // too_few
);
  import plg_pkg::*;

  localparam int unsigned EntryW = 6 * COORD_WIDTH + CNT_W + CtrlW;

  logic              q_full, q_empty, push, pop;
  logic [EntryW-1:0] push_entry, pop_entry;
  logic [AreaW-1:0]  area;
  logic [CNT_W-1:0]  count;

  plg_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_VERTICES(MAX_VERTICES),
    .CNT_W       (CNT_W),
    .ENTRY_W     (EntryW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .x_i       (s_axis_tdata_i[COORD_WIDTH-1:0]),
    .y_i       (s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]),
    .last_i    (s_axis_tlast_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // Decouples vertex bookkeeping from the arithmetic pipeline.
  plg_fifo #(
    .WIDTH(EntryW),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (pop_entry),
    .empty_o(q_empty)
  );

  plg_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_VERTICES(MAX_VERTICES),
    .CNT_W       (CNT_W),
    .ENTRY_W     (EntryW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .area_o     (area),
    .count_o    (count),
    .too_few_o  (m_axis_tuser_o)
  );

  // Pack the result beat; spare top bits are zero.
  assign m_axis_tdata_o = OUT_DATA_W'({count, area});

endmodule

// ===== src/plg_checker.sv =====
// Port-level checker for polygon_shoelace_area, bound to the top level.
// Depends on plg_pkg.
module plg_checker #(
  parameter int unsigned COORD_WIDTH  = plg_pkg::CoordWidthDef,
  parameter int unsigned MAX_VERTICES = plg_pkg::MaxVerticesDef,
  parameter int unsigned CNT_W        = $clog2(MAX_VERTICES + 1),
  parameter int unsigned OUT_DATA_W   = ((plg_pkg::AreaW + CNT_W + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_tvalid_i,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_i,
  input logic                  m_tuser_i
);
  import plg_pkg::*;

  logic [AreaW-1:0] area;
  logic [CNT_W-1:0] count;

  assign area  = m_tdata_i[AreaW-1:0];
  assign count = m_tdata_i[AreaW+CNT_W-1:AreaW];

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result beat changed while stalled");

  // The count lies between one and the saturation limit.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (count != '0) && (count <= CNT_W'(MAX_VERTICES)))
    else $error("vertex count out of range");

  // The too-few flag agrees with the count.
  a_too_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tuser_i == (count < CNT_W'(TooFewLimit))))
    else $error("too-few flag disagrees with vertex count");

  // One or two vertices enclose no area.
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> (area == '0))
    else $error("degenerate polygon with nonzero area");

endmodule

bind polygon_shoelace_area plg_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .MAX_VERTICES(MAX_VERTICES),
  .CNT_W       (CNT_W),
  .OUT_DATA_W  (OUT_DATA_W)
) u_plg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tuser_i (m_axis_tuser_o)
);
